FILE: rtl/pid_controller_step_assert.svh
// Assertion macros used by the checker file of the PID controller.
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pid_pkg.sv
// Package with the types, constants and codes of the PID controller.
package pid_pkg;

  localparam int ErrW   = 24;
  localparam int GainW  = 32;
  localparam int DtW    = 16;
  localparam int IntegW = 48;
  localparam int CorrW  = 32;
  localparam int MulW   = 33;
  localparam int ProdW  = 2 * MulW;
  localparam int DiffW  = ErrW + 1;
  localparam int XW     = DiffW + DtW + 1;
  localparam int TermW  = 76;
  localparam int AccW   = 66;
  localparam int FracW  = 16;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam logic [GainW-1:0] KpReset  = 32'd32768;
  localparam logic [GainW-1:0] KiReset  = 32'd655;
  localparam logic [GainW-1:0] KdReset  = 32'd6554;
  localparam logic [DtW-1:0]   DtReset  = 16'd655;
  localparam logic [DtW-1:0]   InvReset = 16'd100;

  // Limits of the I and D terms, +-2^61 in Q16.16.
  localparam logic signed [TermW-1:0] TermMax = 76'sh000_2000_0000_0000_0000;
  localparam logic signed [TermW-1:0] TermMin = -TermMax;

  typedef enum logic [2:0] {
    REG_KP  = 3'd0,
    REG_KI  = 3'd1,
    REG_KD  = 3'd2,
    REG_DT  = 3'd3,
    REG_INV = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDT,
    ST_KPE,
    ST_DIFF,
    ST_IH,
    ST_IL,
    ST_DH,
    ST_DL,
    ST_DADD,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EDT,
    OP_KPE,
    OP_DIFF,
    OP_IH,
    OP_IL,
    OP_DH,
    OP_DL
  } mul_op_e;

  typedef struct packed {
    mul_op_e op;
    logic    accept;
    logic    upd_integ;
    logic    ld_p;
    logic    ld_x;
    logic    ld_ih;
    logic    add_il;
    logic    add_i;
    logic    add_dl;
    logic    add_d;
    logic    finish;
  } ctrl_t;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
    logic [DtW-1:0]          dt;
    logic [DtW-1:0]          inv;
  } cfg_t;

  typedef struct packed {
    logic signed [ErrW-1:0] error_sample;
    logic                   restart;
  } in_req_t;

  typedef struct packed {
    logic signed [CorrW-1:0] correction;
    logic                    saturated;
  } out_rsp_t;

endpackage

FILE: rtl/pid_regs.sv
// APB register file holding the gains and the time step pair.
module pid_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pid_pkg::AddrW-1:0]  paddr,
  input  logic [pid_pkg::DataW-1:0]  pwdata,
  output logic [pid_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output pid_pkg::cfg_t              cfg_o
);

  pid_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp  <= pid_pkg::KpReset;
      cfg_q.ki  <= pid_pkg::KiReset;
      cfg_q.kd  <= pid_pkg::KdReset;
      cfg_q.dt  <= pid_pkg::DtReset;
      cfg_q.inv <= pid_pkg::InvReset;
    end else if (wr_en) begin
      case (idx)
        pid_pkg::REG_KP:  cfg_q.kp  <= pwdata;
        pid_pkg::REG_KI:  cfg_q.ki  <= pwdata;
        pid_pkg::REG_KD:  cfg_q.kd  <= pwdata;
        pid_pkg::REG_DT:  cfg_q.dt  <= pwdata[pid_pkg::DtW-1:0];
        pid_pkg::REG_INV: cfg_q.inv <= pwdata[pid_pkg::DtW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pid_pkg::REG_KP:  prdata = cfg_q.kp;
      pid_pkg::REG_KI:  prdata = cfg_q.ki;
      pid_pkg::REG_KD:  prdata = cfg_q.kd;
      pid_pkg::REG_DT:  prdata = pid_pkg::DataW'(cfg_q.dt);
      pid_pkg::REG_INV: prdata = pid_pkg::DataW'(cfg_q.inv);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: rtl/pid_mul.sv
// Shared signed multiplier with a registered product.
module pid_mul (
  input  logic                              clk_i,
  input  logic signed [pid_pkg::MulW-1:0]   a_i,
  input  logic signed [pid_pkg::MulW-1:0]   b_i,
  output logic signed [pid_pkg::ProdW-1:0]  prod_o
);

  logic signed [pid_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/pid_ctrl.sv
// Sequencer that steps one sample through the shared multiplier.
module pid_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_busy_i,
  output logic           in_ready_o,
  output pid_pkg::ctrl_t ctrl_o
);

  pid_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pid_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    ctrl_o.op  = pid_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      pid_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          state_d       = pid_pkg::ST_EDT;
        end
      end
      pid_pkg::ST_EDT: begin
        ctrl_o.op = pid_pkg::OP_EDT;
        state_d   = pid_pkg::ST_KPE;
      end
      pid_pkg::ST_KPE: begin
        ctrl_o.op        = pid_pkg::OP_KPE;
        ctrl_o.upd_integ = 1'b1;
        state_d          = pid_pkg::ST_DIFF;
      end
      pid_pkg::ST_DIFF: begin
        ctrl_o.op   = pid_pkg::OP_DIFF;
        ctrl_o.ld_p = 1'b1;
        state_d     = pid_pkg::ST_IH;
      end
      pid_pkg::ST_IH: begin
        ctrl_o.op   = pid_pkg::OP_IH;
        ctrl_o.ld_x = 1'b1;
        state_d     = pid_pkg::ST_IL;
      end
      pid_pkg::ST_IL: begin
        ctrl_o.op    = pid_pkg::OP_IL;
        ctrl_o.ld_ih = 1'b1;
        state_d      = pid_pkg::ST_DH;
      end
      pid_pkg::ST_DH: begin
        ctrl_o.op     = pid_pkg::OP_DH;
        ctrl_o.add_il = 1'b1;
        state_d       = pid_pkg::ST_DL;
      end
      pid_pkg::ST_DL: begin
        ctrl_o.op    = pid_pkg::OP_DL;
        ctrl_o.add_i = 1'b1;
        state_d      = pid_pkg::ST_DADD;
      end
      pid_pkg::ST_DADD: begin
        ctrl_o.add_dl = 1'b1;
        state_d       = pid_pkg::ST_SUM;
      end
      pid_pkg::ST_SUM: begin
        ctrl_o.add_d = 1'b1;
        state_d      = pid_pkg::ST_DONE;
      end
      pid_pkg::ST_DONE: begin
        // Wait here until the output register can take the result.
        if (!out_busy_i) begin
          ctrl_o.finish = 1'b1;
          state_d       = pid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pid_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/pid_controller_step.sv
// Top level of the PID controller: registers, sequencer, shared multiplier and datapath.
//
//   channel   direction  handshake                 payload
//   in        request    in_valid_i / in_ready_o   in_data_i  (error_sample, restart)
//   out       result     out_valid_o / out_ready_i out_data_o (correction, saturated)
//   config    APB        psel, penable, pready     paddr, pwdata, prdata
//
// Each accepted sample runs through the sequencer steps: seven products go through the
// single 33x33 multiplier one per cycle, then the final sums are formed; in_ready_o is
// high only in the idle state. A result that is not taken holds the sequencer in its
// last step; the output register lets the next sample start while the previous result
// still waits to be handed over.
// Reset clears the integral, the last error, the sequencer and the output valid.
module pid_controller_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pid_pkg::in_req_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pid_pkg::out_rsp_t          out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pid_pkg::AddrW-1:0]  paddr,
  input  logic [pid_pkg::DataW-1:0]  pwdata,
  output logic [pid_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  localparam int IntegSumW = pid_pkg::IntegW + 1;
  localparam int ShiftW    = pid_pkg::AccW - pid_pkg::FracW;

  pid_pkg::cfg_t    cfg;
  pid_pkg::ctrl_t   ctrl;

  logic signed [pid_pkg::MulW-1:0]   mul_a, mul_b;
  logic signed [pid_pkg::ProdW-1:0]  prod;

  logic signed [pid_pkg::ErrW-1:0]   err_q;
  logic signed [pid_pkg::ErrW-1:0]   last_q;
  logic signed [pid_pkg::IntegW-1:0] integ_q;
  logic signed [pid_pkg::XW-1:0]     x_q;
  logic signed [pid_pkg::TermW-1:0]  term_q;
  logic signed [pid_pkg::AccW-1:0]   acc_q;
  logic                              sat_q;
  logic                              out_valid_q;
  pid_pkg::out_rsp_t                 out_q;

  logic signed [pid_pkg::DiffW-1:0]  diff;
  logic signed [IntegSumW-1:0]       integ_sum;
  logic                              integ_ovf;
  logic signed [pid_pkg::TermW-1:0]  term_clamp;
  logic                              term_ovf;
  logic signed [ShiftW-1:0]          corr_full;
  logic                              corr_ovf;
  logic signed [pid_pkg::CorrW-1:0]  corr_clamp;

  pid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_valid_q & ~out_ready_i),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  pid_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign diff = pid_pkg::DiffW'(err_q) - pid_pkg::DiffW'(last_q);

  // Operand selection for the shared multiplier; unsigned operands are zero-extended.
  always_comb begin
    case (ctrl.op)
      pid_pkg::OP_EDT: begin
        mul_a = pid_pkg::MulW'(err_q);
        mul_b = signed'({17'b0, cfg.dt});
      end
      pid_pkg::OP_KPE: begin
        mul_a = pid_pkg::MulW'(cfg.kp);
        mul_b = pid_pkg::MulW'(err_q);
      end
      pid_pkg::OP_DIFF: begin
        mul_a = pid_pkg::MulW'(diff);
        mul_b = signed'({17'b0, cfg.inv});
      end
      pid_pkg::OP_IH: begin
        mul_a = pid_pkg::MulW'(cfg.ki);
        mul_b = pid_pkg::MulW'(signed'(integ_q[pid_pkg::IntegW-1:pid_pkg::FracW]));
      end
      pid_pkg::OP_IL: begin
        mul_a = pid_pkg::MulW'(cfg.ki);
        mul_b = signed'({17'b0, integ_q[pid_pkg::FracW-1:0]});
      end
      pid_pkg::OP_DH: begin
        mul_a = pid_pkg::MulW'(cfg.kd);
        mul_b = pid_pkg::MulW'(signed'(x_q[pid_pkg::XW-1:pid_pkg::FracW]));
      end
      pid_pkg::OP_DL: begin
        mul_a = pid_pkg::MulW'(cfg.kd);
        mul_b = signed'({17'b0, x_q[pid_pkg::FracW-1:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The integral grows by error times dt and is held to 48 bits.
  assign integ_sum = IntegSumW'(integ_q) + IntegSumW'(signed'(prod[40:0]));
  assign integ_ovf = integ_sum[IntegSumW-1] != integ_sum[IntegSumW-2];

  always_comb begin
    term_ovf = 1'b1;
    if (term_q > pid_pkg::TermMax) begin
      term_clamp = pid_pkg::TermMax;
    end else if (term_q < pid_pkg::TermMin) begin
      term_clamp = pid_pkg::TermMin;
    end else begin
      term_clamp = term_q;
      term_ovf   = 1'b0;
    end
  end

  // The correction is the accumulated Q16.16 sum floored to an integer.
  assign corr_full = ShiftW'(acc_q >>> pid_pkg::FracW);
  assign corr_ovf  = (corr_full[ShiftW-1:pid_pkg::CorrW-1] != '0) &&
                     (corr_full[ShiftW-1:pid_pkg::CorrW-1] != '1);

  always_comb begin
    if (!corr_ovf) begin
      corr_clamp = corr_full[pid_pkg::CorrW-1:0];
    end else if (corr_full[ShiftW-1]) begin
      corr_clamp = {1'b1, {(pid_pkg::CorrW-1){1'b0}}};
    end else begin
      corr_clamp = {1'b0, {(pid_pkg::CorrW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
    end else begin
      if (ctrl.accept && in_data_i.restart) begin
        integ_q <= '0;
        last_q  <= '0;
      end
      if (ctrl.upd_integ) begin
        if (!integ_ovf) begin
          integ_q <= integ_sum[pid_pkg::IntegW-1:0];
        end else begin
          integ_q <= {integ_sum[IntegSumW-1], {(pid_pkg::IntegW-1){~integ_sum[IntegSumW-1]}}};
        end
      end
      if (ctrl.ld_x) begin
        last_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      err_q <= in_data_i.error_sample;
      sat_q <= 1'b0;
    end
    if (ctrl.upd_integ && integ_ovf) begin
      sat_q <= 1'b1;
    end
    if (ctrl.ld_p) begin
      acc_q <= pid_pkg::AccW'(prod);
    end
    if (ctrl.ld_x) begin
      x_q <= prod[pid_pkg::XW-1:0];
    end
    if (ctrl.ld_ih) begin
      term_q <= pid_pkg::TermW'(prod);
    end
    if (ctrl.add_il) begin
      term_q <= term_q + pid_pkg::TermW'(prod >>> pid_pkg::FracW);
    end
    if (ctrl.add_i) begin
      acc_q  <= acc_q + pid_pkg::AccW'(term_clamp);
      term_q <= pid_pkg::TermW'(prod) <<< pid_pkg::FracW;
      if (term_ovf) begin
        sat_q <= 1'b1;
      end
    end
    if (ctrl.add_dl) begin
      term_q <= term_q + pid_pkg::TermW'(prod);
    end
    if (ctrl.add_d) begin
      acc_q <= acc_q + pid_pkg::AccW'(term_clamp);
      if (term_ovf) begin
        sat_q <= 1'b1;
      end
    end
    if (ctrl.finish) begin
      out_q.correction <= corr_clamp;
      out_q.saturated  <= sat_q | corr_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/pid_check.sv
// Port-level checker for the PID controller and its bind to the top level.
`include "pid_controller_step_assert.svh"

module pid_check (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input pid_pkg::in_req_t           in_data_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input pid_pkg::out_rsp_t          out_data_o,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [pid_pkg::AddrW-1:0]  paddr,
  input logic [pid_pkg::DataW-1:0]  pwdata,
  input logic [pid_pkg::DataW-1:0]  prdata,
  input logic                       pready
);

  logic in_acc;

  assign in_acc = in_valid_i & in_ready_o;

  // Only one request is in work at a time.
  `PID_ASSERT_NXT(a_one_in_work, in_acc, !in_ready_o, "request accepted while another is in work")

  // A new result only comes out of a busy sequencer.
  `PID_ASSERT_IMP(a_result_from_work, $rose(out_valid_o), !$past(in_ready_o), "result without work")

  // A waiting result keeps its value.
  `PID_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(out_data_o), "stalled result changed")

  // The register port never inserts wait states.
  `PID_ASSERT_IMP(a_pready_high, psel && penable, pready, "APB wait state seen")

endmodule

bind pid_controller_step pid_check u_check (.*);

FILE: verif/tb.sv
// Self-checking testbench for the PID controller: directed table, randomized phases, then windup runs.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [2:0]                       cfg_sel;
    logic signed [pid_pkg::ErrW-1:0]  err;
    logic                             restart;
    logic                             typed;
    logic signed [pid_pkg::CorrW-1:0] exp_corr;
    logic                             exp_sat;
  } dir_row_t;

  localparam int DirCount  = 24;
  localparam int RandItems = 450;
  localparam int WindupLen = 300;
  localparam int ErrMax    = (1 << (pid_pkg::ErrW - 1)) - 1;
  localparam int ErrMin    = -(1 << (pid_pkg::ErrW - 1));

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  pid_pkg::in_req_t          in_data_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  pid_pkg::out_rsp_t         out_data_o;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [pid_pkg::AddrW-1:0] paddr = '0;
  logic [pid_pkg::DataW-1:0] pwdata = '0;
  logic [pid_pkg::DataW-1:0] prdata;
  logic                      pready;

  pid_controller_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk_i = ~clk_i;

  // Testbench copy of the controller registers and state.
  logic signed [pid_pkg::GainW-1:0]  gain_p = pid_pkg::KpReset;
  logic signed [pid_pkg::GainW-1:0]  gain_i = pid_pkg::KiReset;
  logic signed [pid_pkg::GainW-1:0]  gain_d = pid_pkg::KdReset;
  logic [pid_pkg::DtW-1:0]           dt_q = pid_pkg::DtReset;
  logic [pid_pkg::DtW-1:0]           inv_q = pid_pkg::InvReset;
  logic signed [pid_pkg::IntegW-1:0] integ_acc = '0;
  logic signed [pid_pkg::ErrW-1:0]   prev_err = '0;

  pid_pkg::out_rsp_t corr_queue[$];
  int                mismatches = 0;
  bit                quiet = 1'b0;

  dir_row_t      dir_rows [DirCount];
  pid_pkg::cfg_t dir_cfgs [5];

  function automatic pid_pkg::out_rsp_t pid_predict(input pid_pkg::in_req_t req);
    wide_t             kp_w, ki_w, kd_w, dt_w, inv_w, e_w, last_w, integ, hi, lo;
    wide_t             p_t, i_t, d_t, s, c, lim, imax, imin, cmax, cmin;
    logic              sat;
    pid_pkg::out_rsp_t r;
    lim  = wide_t'(1) <<< 61;
    imax = (wide_t'(1) <<< 47) - 1;
    imin = -(wide_t'(1) <<< 47);
    cmax = (wide_t'(1) <<< 31) - 1;
    cmin = -(wide_t'(1) <<< 31);
    sat  = 1'b0;
    if (req.restart) begin
      integ_acc = '0;
      prev_err  = '0;
    end
    kp_w   = wide_t'(gain_p);
    ki_w   = wide_t'(gain_i);
    kd_w   = wide_t'(gain_d);
    dt_w   = wide_t'(dt_q);
    inv_w  = wide_t'(inv_q);
    e_w    = wide_t'(req.error_sample);
    last_w = wide_t'(prev_err);
    integ  = wide_t'(integ_acc);

    p_t   = kp_w * e_w;
    integ = integ + e_w * dt_w;
    if (integ > imax) begin
      integ = imax;
      sat   = 1'b1;
    end
    if (integ < imin) begin
      integ = imin;
      sat   = 1'b1;
    end
    // Split the integral so the fractional part is floored separately.
    hi  = integ >>> 16;
    lo  = integ - (hi <<< 16);
    i_t = ki_w * hi + ((ki_w * lo) >>> 16);
    if (i_t > lim) begin
      i_t = lim;
      sat = 1'b1;
    end
    if (i_t < -lim) begin
      i_t = -lim;
      sat = 1'b1;
    end
    d_t = kd_w * ((e_w - last_w) * inv_w);
    if (d_t > lim) begin
      d_t = lim;
      sat = 1'b1;
    end
    if (d_t < -lim) begin
      d_t = -lim;
      sat = 1'b1;
    end
    integ_acc = integ[pid_pkg::IntegW-1:0];
    prev_err  = req.error_sample;

    s = p_t + i_t + d_t;
    c = s >>> 16;
    if (c > cmax) begin
      c   = cmax;
      sat = 1'b1;
    end
    if (c < cmin) begin
      c   = cmin;
      sat = 1'b1;
    end
    r.correction = c[pid_pkg::CorrW-1:0];
    r.saturated  = sat;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [pid_pkg::GainW-1:0] rand_gain();
    logic [pid_pkg::GainW-1:0] mag;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return $urandom();
      default: begin
        mag = $urandom_range(0, 1 << 18);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic logic [pid_pkg::DtW-1:0] rand_period();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 2000));
    endcase
  endfunction

  function automatic pid_pkg::in_req_t rand_req(input bit neg);
    pid_pkg::in_req_t req;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      req.error_sample = 24'($urandom());
    end else if (r < 65) begin
      req.error_sample = 24'(int'($urandom_range(0, 2000)) - 1000);
    end else if (r < 85) begin
      req.error_sample = 24'($urandom_range(1 << 22, ErrMax));
      if (neg) req.error_sample = -req.error_sample;
    end else begin
      case ($urandom_range(0, 4))
        0: req.error_sample = 24'(ErrMax);
        1: req.error_sample = 24'(ErrMin);
        2: req.error_sample = '0;
        3: req.error_sample = '1;
        default: req.error_sample = 24'd1;
      endcase
    end
    req.restart = ($urandom_range(0, 24) == 0);
    return req;
  endfunction

  // One APB transfer; the bus is left selected so transfers can run back to back.
  task automatic apb_xfer(input int idx, input bit wr, input logic [pid_pkg::DataW-1:0] wdata,
                          output logic [pid_pkg::DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= pid_pkg::AddrW'(idx * 4);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
  endtask

  task automatic cfg_write(input int idx, input logic [pid_pkg::DataW-1:0] val);
    logic [pid_pkg::DataW-1:0] unused;
    apb_xfer(idx, 1'b1, val, unused);
    case (idx)
      pid_pkg::REG_KP:  gain_p = val;
      pid_pkg::REG_KI:  gain_i = val;
      pid_pkg::REG_KD:  gain_d = val;
      pid_pkg::REG_DT:  dt_q = val[pid_pkg::DtW-1:0];
      pid_pkg::REG_INV: inv_q = val[pid_pkg::DtW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(input pid_pkg::cfg_t c);
    logic [pid_pkg::DataW-1:0] got, want;
    cfg_write(pid_pkg::REG_KP, c.kp);
    cfg_write(pid_pkg::REG_KI, c.ki);
    cfg_write(pid_pkg::REG_KD, c.kd);
    cfg_write(pid_pkg::REG_DT, {16'($urandom()), c.dt});
    cfg_write(pid_pkg::REG_INV, {16'($urandom()), c.inv});
    // Writes to addresses past the last register must not disturb anything.
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(int'(pid_pkg::REG_INV) + $urandom_range(1, 3), $urandom());
    end
    for (int k = pid_pkg::REG_KP; k <= pid_pkg::REG_INV; k++) begin
      apb_xfer(k, 1'b0, '0, got);
      case (k)
        pid_pkg::REG_KP:  want = gain_p;
        pid_pkg::REG_KI:  want = gain_i;
        pid_pkg::REG_KD:  want = gain_d;
        pid_pkg::REG_DT:  want = {16'h0, dt_q};
        default:          want = {16'h0, inv_q};
      endcase
      if (k >= pid_pkg::REG_DT) begin
        got  = {16'h0, got[pid_pkg::DtW-1:0]};
      end
      if (got !== want) begin
        $display("%0t: register %0d readback expected %h got %h", $time, k, want, got);
        mismatches++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input pid_pkg::in_req_t req, input bit typed,
                             input pid_pkg::out_rsp_t typed_rsp);
    int                gap;
    pid_pkg::out_rsp_t pred;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = pid_predict(req);
    corr_queue.push_back(typed ? typed_rsp : pred);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (corr_queue.size() != 0) @(posedge clk_i);
  endtask

  initial begin : ready_gen
    int stall;
    forever begin
      out_ready_i <= 1'b1;
      if (quiet) begin
        @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        stall = pick_gap();
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : rsp_check
    pid_pkg::out_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (corr_queue.size() == 0) begin
        $display("%0t: unexpected result: correction %0d saturated %0b", $time,
                 $signed(out_data_o.correction), out_data_o.saturated);
        mismatches++;
      end else begin
        want = corr_queue.pop_front();
        if (out_data_o.correction !== want.correction) begin
          $display("%0t: correction expected %0d got %0d", $time,
                   $signed(want.correction), $signed(out_data_o.correction));
          mismatches++;
        end
        if (out_data_o.saturated !== want.saturated) begin
          $display("%0t: saturated expected %0b got %0b", $time,
                   want.saturated, out_data_o.saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    dir_row_t          row;
    pid_pkg::in_req_t  req;
    pid_pkg::out_rsp_t typed_rsp;
    int                cur_sel;
    int                sent;
    int                phase_len;
    bit                neg;

    dir_cfgs = '{
      '{pid_pkg::KpReset, pid_pkg::KiReset, pid_pkg::KdReset, pid_pkg::DtReset,
        pid_pkg::InvReset},
      '{32'sh0001_0000, 32'sh0, 32'sh0, 16'd655, 16'd100},
      '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 16'hFFFF},
      '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd1, 16'd1},
      '{32'sd6554, 32'sh0001_0000, 32'sh0001_0000, 16'd0, 16'd0}
    };
    // Columns: gain set, error, restart, typed expectation, correction, saturated.
    dir_rows = '{
      '{3'd0, 24'sd0,       1'b1, 1'b1, 32'sd0,        1'b0},
      '{3'd0, 24'(ErrMax),  1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd0, 24'(ErrMin),  1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd0, -24'sd1,      1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd0, 24'sd1,       1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd0, 24'sd12345,   1'b1, 1'b0, 32'sd0,        1'b0},
      '{3'd1, 24'(ErrMax),  1'b1, 1'b1, ErrMax,        1'b0},
      '{3'd1, 24'(ErrMin),  1'b0, 1'b1, ErrMin,        1'b0},
      '{3'd1, 24'sd0,       1'b0, 1'b1, 32'sd0,        1'b0},
      '{3'd1, -24'sd1,      1'b0, 1'b1, -32'sd1,       1'b0},
      '{3'd2, 24'(ErrMax),  1'b1, 1'b0, 32'sd0,        1'b0},
      '{3'd2, 24'(ErrMax),  1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd2, 24'(ErrMax),  1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd2, 24'(ErrMax),  1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd2, 24'(ErrMin),  1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd2, 24'(ErrMin),  1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd3, 24'(ErrMin),  1'b1, 1'b0, 32'sd0,        1'b0},
      '{3'd3, 24'(ErrMin),  1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd3, 24'(ErrMax),  1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd3, 24'sd0,       1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd4, 24'sd100,     1'b1, 1'b0, 32'sd0,        1'b0},
      '{3'd4, -24'sd100,    1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd4, 24'(ErrMax),  1'b0, 1'b0, 32'sd0,        1'b0},
      '{3'd4, 24'sd0,       1'b1, 1'b0, 32'sd0,        1'b0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_sel = 0;
    for (int n = 0; n < DirCount; n++) begin
      row = dir_rows[n];
      if (row.cfg_sel != cur_sel) begin
        wait_drained();
        load_cfg(dir_cfgs[row.cfg_sel]);
        cur_sel = row.cfg_sel;
      end
      req.error_sample     = row.err;
      req.restart          = row.restart;
      typed_rsp.correction = row.exp_corr;
      typed_rsp.saturated  = row.exp_sat;
      send_sample(req, row.typed, typed_rsp);
    end

    sent = 0;
    while (sent < RandItems) begin
      wait_drained();
      quiet = ($urandom_range(0, 3) == 0);
      load_cfg('{rand_gain(), rand_gain(), rand_gain(), rand_period(), rand_period()});
      phase_len = $urandom_range(10, 80);
      neg       = $urandom_range(0, 1);
      for (int n = 0; n < phase_len; n++) send_sample(rand_req(neg), 1'b0, '0);
      sent += phase_len;
    end

    // Drive the integral into both clamps with long runs of large errors.
    for (int dir = 0; dir < 2; dir++) begin
      wait_drained();
      quiet = 1'b0;
      load_cfg('{32'sd6554, 32'sh0001_0000, 32'sh0, 16'hFFFF, 16'd1});
      for (int n = 0; n < WindupLen; n++) begin
        req.error_sample = 24'($urandom_range(7 << 20, ErrMax));
        if (dir == 1) req.error_sample = -req.error_sample;
        req.restart = (n == 0);
        send_sample(req, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && corr_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/pid_pkg.sv
rtl/pid_regs.sv
rtl/pid_mul.sv
rtl/pid_ctrl.sv
rtl/pid_controller_step.sv
rtl/pid_check.sv
verif/tb.sv
